// ===== design/strided_array_offset_generator_core_macros.svh =====
// Assertion macros for the strided array offset generator.
`ifndef STRIDED_ARRAY_OFFSET_GENERATOR_CORE_MACROS_SVH
`define STRIDED_ARRAY_OFFSET_GENERATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SAOG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SAOG_ASSERT_DELAY(lbl, ante, dly, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##dly (cons)) \
    else $error("assertion failed");
`else
`define SAOG_ASSERT_IMPL(lbl, ante, cons)
`define SAOG_ASSERT_DELAY(lbl, ante, dly, cons)
`endif
`endif

// ===== design/saog_pkg.sv =====
// Shared types and constants of the strided array offset generator.
package saog_pkg;

  localparam int FLAT_W  = 64;
  localparam int PACK_W  = 64;
  localparam int IDX_W   = 16;
  localparam int NUM_IDX = 4;
  localparam int OFS_W   = 34;
  localparam int NUM_W   = 4;

  typedef enum logic [1:0] {
    REG_WALK_ORDER = 2'd0,
    REG_RANK       = 2'd1,
    REG_EXTENTS    = 2'd2,
    REG_STRIDES    = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_FLAT  = 1'b0,
    OP_MULTI = 1'b1
  } op_e;

  typedef struct packed {
    logic valid;
    op_e  op;
    logic status;
  } ctl_t;

endpackage

// ===== design/strided_array_offset_generator_core.sv =====
// Strided N-dimensional array offset generator, top level.
// Each item passes MAX_RANK dimension groups on its way from start to valid_o:
// per dimension, 64 restoring division cells plus one multiply-accumulate cell.
// Throughput: one item per cycle; busy stays low, results cannot be stalled.
// Reset clears configuration to zero and empties the cell chain.
module strided_array_offset_generator_core #(
  parameter int MAX_RANK    = 4,
  parameter int EXTENT_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         op_i,
  input  logic [63:0]                  flat_index_i,
  input  logic [15:0]                  index_0_i,
  input  logic [15:0]                  index_1_i,
  input  logic [15:0]                  index_2_i,
  input  logic [15:0]                  index_3_i,
  output logic                         valid_o,
  output logic [33:0]                  byte_offset_o,
  output logic                         status_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [63:0]                  cfg_data_i
);

  `include "strided_array_offset_generator_core_macros.svh"

  localparam int EXT_W  = EXTENT_BITS;
  localparam int STEPS  = saog_pkg::FLAT_W;
  localparam int GROUP  = STEPS + 1;
  localparam int NODES  = MAX_RANK * GROUP;
  localparam int PK_W   = saog_pkg::PACK_W + MAX_RANK * EXT_W;
  localparam int NW     = saog_pkg::NUM_W;

  logic                        walk_q;
  logic [2:0]                  rank_q;
  logic [saog_pkg::PACK_W-1:0] extents_q, strides_q;
  logic [NW-1:0]               n_used;
  logic [PK_W-1:0]             ext_wide, str_wide;

  saog_pkg::ctl_t                ctl_n [NODES+1];
  logic [saog_pkg::OFS_W-1:0]    ofs_n [NODES+1];
  logic [EXT_W-1:0]              rem_n [NODES+1];
  logic [saog_pkg::FLAT_W-1:0]   qd_n  [NODES+1];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q    <= 1'b0;
      rank_q    <= '0;
      extents_q <= '0;
      strides_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (saog_pkg::cfg_reg_e'(cfg_index_i))
        saog_pkg::REG_WALK_ORDER: walk_q    <= cfg_data_i[0];
        saog_pkg::REG_RANK:       rank_q    <= cfg_data_i[2:0];
        saog_pkg::REG_EXTENTS:    extents_q <= cfg_data_i;
        saog_pkg::REG_STRIDES:    strides_q <= cfg_data_i;
      endcase
    end
  end

  assign n_used   = ({1'b0, rank_q} > NW'(MAX_RANK)) ? NW'(MAX_RANK) : {1'b0, rank_q};
  assign ext_wide = PK_W'(extents_q);
  assign str_wide = PK_W'(strides_q);

  assign ctl_n[0] = '{valid: start && !busy, op: saog_pkg::op_e'(op_i), status: 1'b0};
  assign ofs_n[0] = '0;
  assign rem_n[0] = '0;
  assign qd_n[0]  = op_i ? {index_3_i, index_2_i, index_1_i, index_0_i} : flat_index_i;

  for (genvar j = 0; j < MAX_RANK; j++) begin : g_dim
    logic [NW-1:0]    d_sel;
    logic [EXT_W-1:0] ext_g, str_g;
    logic [EXT_W-1:0] ext_dim, str_dim;
    logic             active;

    assign ext_dim = ext_wide[j*EXT_W +: EXT_W];
    assign str_dim = str_wide[j*EXT_W +: EXT_W];

    always_comb begin
      d_sel  = walk_q ? NW'(j) : n_used - NW'(j) - NW'(1);
      active = NW'(j) < n_used;
      ext_g  = '0;
      str_g  = '0;
      for (int k = 0; k < MAX_RANK; k++) begin
        if (d_sel == NW'(k)) begin
          ext_g = ext_wide[k*EXT_W +: EXT_W];
          str_g = str_wide[k*EXT_W +: EXT_W];
        end
      end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
      saog_div_cell #(.EXT_W(EXT_W)) u_div (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctl_i  (ctl_n[j*GROUP+k]),
        .ofs_i  (ofs_n[j*GROUP+k]),
        .rem_i  (rem_n[j*GROUP+k]),
        .qd_i   (qd_n[j*GROUP+k]),
        .ext_i  (ext_g),
        .ctl_o  (ctl_n[j*GROUP+k+1]),
        .ofs_o  (ofs_n[j*GROUP+k+1]),
        .rem_o  (rem_n[j*GROUP+k+1]),
        .qd_o   (qd_n[j*GROUP+k+1])
      );
    end

    saog_dim_cell #(.EXT_W(EXT_W), .DIM(j)) u_fin (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl_n[j*GROUP+STEPS]),
      .ofs_i        (ofs_n[j*GROUP+STEPS]),
      .rem_i        (rem_n[j*GROUP+STEPS]),
      .qd_i         (qd_n[j*GROUP+STEPS]),
      .active_i     (active),
      .ext_i        (ext_g),
      .stride_i     (str_g),
      .ext_dim_i    (ext_dim),
      .stride_dim_i (str_dim),
      .ctl_o        (ctl_n[j*GROUP+GROUP]),
      .ofs_o        (ofs_n[j*GROUP+GROUP]),
      .rem_o        (rem_n[j*GROUP+GROUP]),
      .qd_o         (qd_n[j*GROUP+GROUP])
    );
  end

  assign valid_o       = ctl_n[NODES].valid;
  assign status_o      = ctl_n[NODES].status;
  assign byte_offset_o = ctl_n[NODES].status ? '0 : ofs_n[NODES];

  `SAOG_ASSERT_IMPL(a_oob_zero, valid_o && status_o, byte_offset_o == '0)
  `SAOG_ASSERT_DELAY(a_latency, start && !busy, NODES, valid_o)
  `SAOG_ASSERT_IMPL(a_flat_ok, valid_o && ctl_n[NODES].op == saog_pkg::OP_FLAT, !status_o)

endmodule

// ===== design/saog_div_cell.sv =====
// One restoring division step: on flat items shifts one dividend bit in, one quotient bit out; explicit ones pass.
module saog_div_cell #(
  parameter int EXT_W = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  saog_pkg::ctl_t            ctl_i,
  input  logic [saog_pkg::OFS_W-1:0]  ofs_i,
  input  logic [EXT_W-1:0]          rem_i,
  input  logic [saog_pkg::FLAT_W-1:0] qd_i,
  input  logic [EXT_W-1:0]          ext_i,
  output saog_pkg::ctl_t            ctl_o,
  output logic [saog_pkg::OFS_W-1:0]  ofs_o,
  output logic [EXT_W-1:0]          rem_o,
  output logic [saog_pkg::FLAT_W-1:0] qd_o
);

  saog_pkg::ctl_t                ctl_q;
  logic [saog_pkg::OFS_W-1:0]    ofs_q;
  logic [EXT_W-1:0]              rem_q, rem_d;
  logic [saog_pkg::FLAT_W-1:0]   qd_q, qd_d;
  logic [EXT_W:0]                r_ext, r_sub;
  logic                          ge;

  always_comb begin
    r_ext = {rem_i, qd_i[saog_pkg::FLAT_W-1]};
    ge    = r_ext >= {1'b0, ext_i};
    r_sub = r_ext - {1'b0, ext_i};
    if (ctl_i.op == saog_pkg::OP_FLAT) begin
      rem_d = ge ? r_sub[EXT_W-1:0] : r_ext[EXT_W-1:0];
      qd_d  = {qd_i[saog_pkg::FLAT_W-2:0], ge};
    end else begin
      rem_d = rem_i;
      qd_d  = qd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    ofs_q <= ofs_i;
    rem_q <= rem_d;
    qd_q  <= qd_d;
  end

  assign ctl_o = ctl_q;
  assign ofs_o = ofs_q;
  assign rem_o = rem_q;
  assign qd_o  = qd_q;

endmodule

// ===== design/saog_dim_cell.sv =====
// Per-dimension finish: picks the index, checks bounds of explicit indices, adds index times stride.
module saog_dim_cell #(
  parameter int EXT_W = 16,
  parameter int DIM   = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  saog_pkg::ctl_t            ctl_i,
  input  logic [saog_pkg::OFS_W-1:0]  ofs_i,
  input  logic [EXT_W-1:0]          rem_i,
  input  logic [saog_pkg::FLAT_W-1:0] qd_i,
  input  logic                      active_i,
  input  logic [EXT_W-1:0]          ext_i,
  input  logic [EXT_W-1:0]          stride_i,
  input  logic [EXT_W-1:0]          ext_dim_i,
  input  logic [EXT_W-1:0]          stride_dim_i,
  output saog_pkg::ctl_t            ctl_o,
  output logic [saog_pkg::OFS_W-1:0]  ofs_o,
  output logic [EXT_W-1:0]          rem_o,
  output logic [saog_pkg::FLAT_W-1:0] qd_o
);

  localparam int IW = (EXT_W > saog_pkg::IDX_W) ? EXT_W : saog_pkg::IDX_W;
  localparam int PW = IW + EXT_W;
  localparam int SW = (PW > saog_pkg::OFS_W) ? PW : saog_pkg::OFS_W;

  saog_pkg::ctl_t                ctl_q, ctl_d;
  logic [saog_pkg::OFS_W-1:0]    ofs_q, ofs_d;
  logic [saog_pkg::FLAT_W-1:0]   qd_q, qd_d;
  logic [IW-1:0]                 idx_multi, idx_sel, ext_w;
  logic [EXT_W-1:0]              str_sel;
  logic [SW-1:0]                 prod;
  logic                          ext_zero, add_en;

  if (DIM < saog_pkg::NUM_IDX) begin : g_idx
    assign idx_multi = IW'(qd_i[DIM*saog_pkg::IDX_W +: saog_pkg::IDX_W]);
  end else begin : g_noidx
    assign idx_multi = '0;
  end

  // flat transfers walk dimensions in configured order; explicit ones use dimension DIM
  always_comb begin
    ext_w    = IW'(ext_dim_i);
    ext_zero = (ext_i == '0);
    ctl_d    = ctl_i;
    qd_d     = qd_i;
    add_en   = 1'b0;
    idx_sel  = '0;
    str_sel  = stride_i;
    if (ctl_i.op == saog_pkg::OP_FLAT) begin
      idx_sel = ext_zero ? '0 : IW'(rem_i);
      if (active_i) begin
        add_en = 1'b1;
        if (ext_zero) qd_d = '0;
      end
    end else begin
      idx_sel = idx_multi;
      str_sel = stride_dim_i;
      if (active_i && !ctl_i.status) begin
        if (idx_multi >= ext_w) begin
          ctl_d.status = 1'b1;
        end else begin
          add_en = 1'b1;
        end
      end
    end
    prod  = SW'(idx_sel) * SW'(str_sel);
    ofs_d = add_en ? ofs_i + prod[saog_pkg::OFS_W-1:0] : ofs_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ofs_q <= ofs_d;
    qd_q  <= qd_d;
  end

  assign ctl_o = ctl_q;
  assign ofs_o = ofs_q;
  assign rem_o = '0;
  assign qd_o  = qd_q;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the strided array offset generator core.
`timescale 1ns / 1ps

module testbench;

  localparam int LATENCY = 260;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [33:0] byte_offset;
    logic        status;
  } offset_result_t;

  class offset_scoreboard;
    logic        walk_order;
    logic [2:0]  rank;
    logic [63:0] extents;
    logic [63:0] strides;
    offset_result_t pending[$];
    int errors;

    function new();
      walk_order = 0;
      rank = 0;
      extents = 0;
      strides = 0;
      errors = 0;
    endfunction

    function void write_reg(saog_pkg::cfg_reg_e idx, logic [63:0] data);
      case (idx)
        saog_pkg::REG_WALK_ORDER: walk_order = data[0];
        saog_pkg::REG_RANK:       rank = data[2:0];
        saog_pkg::REG_EXTENTS:    extents = data;
        saog_pkg::REG_STRIDES:    strides = data;
      endcase
    endfunction

    function void note_item(saog_pkg::op_e op, logic [63:0] flat, logic [15:0] i0,
                            logic [15:0] i1, logic [15:0] i2, logic [15:0] i3);
      int n;
      int d;
      logic [63:0] q;
      logic [63:0] ext;
      logic [63:0] ix;
      logic [63:0] ofs;
      logic [15:0] idx[4];
      offset_result_t r;
      n = (rank > 4) ? 4 : rank;
      ofs = 0;
      r.status = 0;
      idx[0] = i0; idx[1] = i1; idx[2] = i2; idx[3] = i3;
      if (n != 0) begin
        if (op == saog_pkg::OP_FLAT) begin
          q = flat;
          for (int j = 0; j < n; j++) begin
            d = walk_order ? j : n - 1 - j;
            ext = extents[d*16 +: 16];
            ix = 0;
            if (ext != 0) begin
              ix = q % ext;
              q = q / ext;
            end else begin
              q = 0;
            end
            ofs += ix * strides[d*16 +: 16];
          end
        end else begin
          for (int j = 0; j < n; j++) begin
            if (idx[j] >= extents[j*16 +: 16]) begin
              r.status = 1;
              break;
            end
            ofs += idx[j] * strides[j*16 +: 16];
          end
          if (r.status) ofs = 0;
        end
      end
      r.byte_offset = ofs[33:0];
      pending = {pending, r};
    endfunction

    function void check_result(logic [33:0] ofs, logic st);
      offset_result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result ofs=%0h status=%0b", $time, ofs, st);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.byte_offset !== ofs) begin
        $display("%0t: byte_offset expected %0h actual %0h", $time, e.byte_offset, ofs);
        errors++;
      end
      if (e.status !== st) begin
        $display("%0t: status expected %0b actual %0b", $time, e.status, st);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic        op_i = 0;
  logic [63:0] flat_index_i = 0;
  logic [15:0] index_0_i = 0, index_1_i = 0, index_2_i = 0, index_3_i = 0;
  logic        valid_o;
  logic [33:0] byte_offset_o;
  logic        status_o;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = 0;
  logic [63:0] cfg_data_i = 0;

  offset_scoreboard sb = new();
  int idle_pct;
  int stall_cnt;

  always #6 clk_i = ~clk_i;

  strided_array_offset_generator_core dut (.*);

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) sb.check_result(byte_offset_o, status_o);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || valid_o || (cfg_valid_i && cfg_ready_o))
      stall_cnt <= 0;
    else
      stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic write_cfg(saog_pkg::cfg_reg_e idx, logic [63:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic set_config(logic wo, logic [2:0] rk, logic [63:0] ex, logic [63:0] st);
    drain();
    write_cfg(saog_pkg::REG_WALK_ORDER, {63'd0, wo});
    write_cfg(saog_pkg::REG_RANK, {61'd0, rk});
    write_cfg(saog_pkg::REG_EXTENTS, ex);
    write_cfg(saog_pkg::REG_STRIDES, st);
  endtask

  // holds start across back-to-back items; lowers it only on an idle cycle
  task automatic send_item(saog_pkg::op_e op, logic [63:0] flat, logic [15:0] i0,
                           logic [15:0] i1, logic [15:0] i2, logic [15:0] i3);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk_i);
    end
    start <= 1;
    op_i <= op;
    flat_index_i <= flat;
    index_0_i <= i0; index_1_i <= i1; index_2_i <= i2; index_3_i <= i3;
    do @(posedge clk_i); while (busy);
    sb.note_item(op, flat, i0, i1, i2, i3);
    @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [15:0] pick_idx(logic [15:0] ext);
    case ($urandom_range(5))
      0: return 16'hffff;
      1: return ext;
      2: return (ext == 0) ? 16'd0 : ext - 1;
      default: return (ext == 0) ? 16'd0 : 16'($urandom_range(ext - 1));
    endcase
  endfunction

  task automatic random_items(int cnt);
    logic [63:0] ex;
    logic [63:0] fl;
    ex = sb.extents;
    for (int k = 0; k < cnt; k++) begin
      case ($urandom_range(3))
        0: fl = rand64();
        1: fl = 64'($urandom_range(100000));
        2: fl = ~64'($urandom_range(3));
        default: fl = 64'($urandom);
      endcase
      send_item(saog_pkg::op_e'($urandom_range(1)), fl, pick_idx(ex[15:0]),
                pick_idx(ex[31:16]), pick_idx(ex[47:32]), pick_idx(ex[63:48]));
    end
    start <= 0;
  endtask

  task automatic random_config();
    logic [63:0] ex;
    logic [63:0] st;
    for (int d = 0; d < 4; d++) begin
      case ($urandom_range(4))
        0: ex[d*16 +: 16] = 0;
        1: ex[d*16 +: 16] = 16'hffff;
        default: ex[d*16 +: 16] = 16'($urandom_range(1, 40));
      endcase
      st[d*16 +: 16] = ($urandom_range(3) == 0) ? 16'hffff : 16'($urandom);
    end
    set_config(1'($urandom_range(1)), 3'($urandom_range(7)), ex, st);
  endtask

  initial begin
    idle_pct = 0;
    stall_cnt = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // rank zero at reset
    send_item(saog_pkg::OP_FLAT, 64'd12345, 0, 0, 0, 0);
    send_item(saog_pkg::OP_MULTI, 0, 16'hffff, 0, 0, 0);
    start <= 0;
    set_config(0, 4, 64'h0005_0004_0003_0002, 64'h0100_0040_0010_0004);
    send_item(saog_pkg::OP_FLAT, 0, 0, 0, 0, 0);
    send_item(saog_pkg::OP_FLAT, 64'd119, 0, 0, 0, 0);
    send_item(saog_pkg::OP_FLAT, 64'd120, 0, 0, 0, 0);
    send_item(saog_pkg::OP_FLAT, '1, 0, 0, 0, 0);
    send_item(saog_pkg::OP_MULTI, 0, 1, 2, 3, 4);
    send_item(saog_pkg::OP_MULTI, 0, 2, 0, 0, 0);
    send_item(saog_pkg::OP_MULTI, 0, 0, 0, 0, 5);
    start <= 0;
    set_config(1, 3, 64'hffff_ffff_0000_0007, '1);
    send_item(saog_pkg::OP_FLAT, 64'd1000, 0, 0, 0, 0);
    send_item(saog_pkg::OP_FLAT, '1, 0, 0, 0, 0);
    send_item(saog_pkg::OP_MULTI, 0, 6, 0, 0, 0);
    send_item(saog_pkg::OP_MULTI, 0, 0, 16'hffff, 0, 0);
    start <= 0;
    set_config(0, 7, '1, '1);
    send_item(saog_pkg::OP_FLAT, '1, 0, 0, 0, 0);
    send_item(saog_pkg::OP_MULTI, 0, 16'hfffe, 16'hfffe, 16'hfffe, 16'hfffe);
    send_item(saog_pkg::OP_MULTI, 0, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_item(saog_pkg::OP_MULTI, 64'haaaa_5555_aaaa_5555, 16'haaaa, 16'h5555, 16'haaaa,
              16'h5555);
    start <= 0;

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 11 : (ph == 1) ? 62 : 0;
      for (int c = 0; c < 5; c++) begin
        random_config();
        random_items(30);
      end
    end

    drain();
    if (sb.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end
endmodule
